/* design/tdc_pkg.sv */
// Shared types, constants and a helper function for the time-of-day counter.
`default_nettype none
package tdc_pkg;

	// action codes as they arrive on the input tuser
	localparam logic [1:0] ACT_SET = 2'd0;
	localparam logic [1:0] ACT_ADVANCE = 2'd1;
	localparam logic [1:0] ACT_COMPARE = 2'd2;

	localparam logic [5:0] SEC_WRAP = 6'd60;
	localparam logic [5:0] MIN_WRAP = 6'd60;
	localparam logic [5:0] MIN_SEC_MAX = 6'd59;
	localparam logic [4:0] HOUR_WRAP_12 = 5'd13;
	localparam logic [4:0] HOUR_NOON = 5'd12;
	localparam logic [4:0] HOUR_WRAP_24 = 5'd24;
	localparam logic [5:0] HOUR_MAX_24 = 6'd23;
	localparam logic [5:0] HOUR_MAX_12 = 6'd12;
	localparam logic [5:0] HOUR_MIN_12 = 6'd1;
	localparam logic [6:0] HALF_DAY = 7'd12;

	localparam int IN_DATA_W = 40;
	localparam int OUT_DATA_W = 24;

	typedef enum logic [1:0] {
		KIND_SET = 2'd0,
		KIND_ADVANCE = 2'd1,
		KIND_COMPARE = 2'd2,
		KIND_NOP = 2'd3
	} cmd_kind_t;

	// one classified word, as held in the queue
	typedef struct packed {
		cmd_kind_t kind;
		logic [5:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
		logic pm;
		logic hour_ok;
		logic minute_ok;
		logic second_ok;
		logic [6:0] other_h24;
		logic [16:0] count;
	} cmd_t;

	typedef struct packed {
		logic second_rejected;
		logic minute_rejected;
		logic hour_rejected;
		logic time_greater;
		logic times_equal;
		logic pm;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
	} result_t;

	// hour in 24-hour form; 12-hour form maps AM 12 to 0 and PM h other than 12 to h + 12
	function automatic logic [6:0] hour_to_24(input logic [5:0] h, input logic pm,
			input logic twelve);
		logic [6:0] hx;
		begin
			hx = {1'b0, h};
			if (!twelve) begin
				hour_to_24 = hx;
			end else if (!pm) begin
				hour_to_24 = (h == HOUR_MAX_12) ? 7'd0 : hx;
			end else begin
				hour_to_24 = (h == HOUR_MAX_12) ? hx : hx + HALF_DAY;
			end
		end
	endfunction

endpackage
`default_nettype wire

/* design/tdc_front.sv */
// Front end: takes input words, decodes the action and pre-checks the fields.
`default_nettype none
module tdc_front (
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [1:0] s_tuser,
	input wire logic [tdc_pkg::IN_DATA_W-1:0] s_tdata,
	input wire logic twelve_hour_mode,
	input wire logic q_full,
	output logic q_push,
	output tdc_pkg::cmd_t q_cmd
);

	logic [5:0] hour_in;
	logic [5:0] minute_in;
	logic [5:0] second_in;
	logic pm_in;
	logic other_twelve_hour;
	logic [16:0] advance_count;

	assign hour_in = s_tdata[5:0];
	assign minute_in = s_tdata[11:6];
	assign second_in = s_tdata[17:12];
	assign pm_in = s_tdata[18];
	assign other_twelve_hour = s_tdata[19];
	assign advance_count = s_tdata[36:20];

	assign s_tready = !q_full;
	assign q_push = s_tvalid && !q_full;

	always_comb begin
		case (s_tuser)
			tdc_pkg::ACT_SET: q_cmd.kind = tdc_pkg::KIND_SET;
			tdc_pkg::ACT_ADVANCE: q_cmd.kind = tdc_pkg::KIND_ADVANCE;
			tdc_pkg::ACT_COMPARE: q_cmd.kind = tdc_pkg::KIND_COMPARE;
			default: q_cmd.kind = tdc_pkg::KIND_NOP;
		endcase
		q_cmd.hour = hour_in;
		q_cmd.minute = minute_in;
		q_cmd.second = second_in;
		q_cmd.pm = pm_in;
		q_cmd.hour_ok = twelve_hour_mode
			? (hour_in >= tdc_pkg::HOUR_MIN_12 && hour_in <= tdc_pkg::HOUR_MAX_12)
			: (hour_in <= tdc_pkg::HOUR_MAX_24);
		q_cmd.minute_ok = minute_in <= tdc_pkg::MIN_SEC_MAX;
		q_cmd.second_ok = second_in <= tdc_pkg::MIN_SEC_MAX;
		q_cmd.other_h24 = tdc_pkg::hour_to_24(hour_in, pm_in, other_twelve_hour);
		q_cmd.count = advance_count;
	end

endmodule
`default_nettype wire

/* design/tdc_queue.sv */
// Small FIFO of decoded words between front and back end.
`default_nettype none
module tdc_queue #(
	parameter int DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire tdc_pkg::cmd_t push_cmd,
	output logic full,
	input wire logic pop,
	output logic head_valid,
	output tdc_pkg::cmd_t head_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	tdc_pkg::cmd_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_cmd = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* design/tdc_back.sv */
// Back end: holds the time, runs set / advance / compare and drives the result register.
`default_nettype none
module tdc_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic twelve_hour_mode,
	input wire logic head_valid,
	input wire tdc_pkg::cmd_t head_cmd,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output tdc_pkg::result_t out_result
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN = 2'b10
	} back_state_t;

	back_state_t state_q;
	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;
	logic pm_q;
	logic [16:0] remain_q;
	logic out_valid_q;
	tdc_pkg::result_t out_q;

	logic out_space;
	logic [4:0] tick_hours;
	logic [5:0] tick_minutes;
	logic [5:0] tick_seconds;
	logic tick_pm;
	logic [5:0] sec_inc;
	logic [5:0] min_inc;
	logic [4:0] hour_inc;
	logic [6:0] own_h24;
	logic cmp_eq;
	logic cmp_gt;
	logic start_adv;
	logic emit;
	logic do_tick;
	tdc_pkg::result_t res;

	assign out_space = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_result = out_q;

	// one-second step with cascaded wraps
	always_comb begin
		sec_inc = seconds_q + 6'd1;
		min_inc = minutes_q + 6'd1;
		hour_inc = hours_q + 5'd1;
		tick_seconds = sec_inc;
		tick_minutes = minutes_q;
		tick_hours = hours_q;
		tick_pm = pm_q;
		if (sec_inc == tdc_pkg::SEC_WRAP) begin
			tick_seconds = '0;
			tick_minutes = min_inc;
			if (min_inc == tdc_pkg::MIN_WRAP) begin
				tick_minutes = '0;
				tick_hours = hour_inc;
				if (twelve_hour_mode) begin
					if (hour_inc == tdc_pkg::HOUR_WRAP_12) begin
						tick_hours = 5'd1;
					end else if (hour_inc == tdc_pkg::HOUR_NOON) begin
						tick_pm = !pm_q;
					end
				end else if (hour_inc == tdc_pkg::HOUR_WRAP_24) begin
					tick_hours = '0;
				end
			end
		end
	end

	assign own_h24 = tdc_pkg::hour_to_24({1'b0, hours_q}, pm_q, twelve_hour_mode);
	assign cmp_eq = {own_h24, minutes_q, seconds_q}
		== {head_cmd.other_h24, head_cmd.minute, head_cmd.second};
	assign cmp_gt = {own_h24, minutes_q, seconds_q}
		> {head_cmd.other_h24, head_cmd.minute, head_cmd.second};

	// an advance of more than nothing leaves the queue at once and ticks on its own
	assign start_adv = (state_q == ST_IDLE) && head_valid
		&& (head_cmd.kind == tdc_pkg::KIND_ADVANCE) && (head_cmd.count != '0);
	assign do_tick = start_adv || ((state_q == ST_RUN) && (remain_q != '0));

	always_comb begin
		emit = 1'b0;
		pop = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start_adv) begin
					pop = 1'b1;
				end else if (head_valid && out_space) begin
					pop = 1'b1;
					emit = 1'b1;
				end
			end
			ST_RUN: begin
				emit = (remain_q == '0) && out_space;
			end
			default: begin
				emit = 1'b0;
				pop = 1'b0;
			end
		endcase
	end

	// result after the step; set fields come from the word where accepted
	always_comb begin
		res.hour = hours_q;
		res.minute = minutes_q;
		res.second = seconds_q;
		res.pm = pm_q;
		res.times_equal = 1'b0;
		res.time_greater = 1'b0;
		res.hour_rejected = 1'b0;
		res.minute_rejected = 1'b0;
		res.second_rejected = 1'b0;
		if (state_q == ST_IDLE) begin
			case (head_cmd.kind)
				tdc_pkg::KIND_SET: begin
					if (head_cmd.hour_ok) begin
						res.hour = head_cmd.hour[4:0];
					end
					if (head_cmd.minute_ok) begin
						res.minute = head_cmd.minute;
					end
					if (head_cmd.second_ok) begin
						res.second = head_cmd.second;
					end
					res.pm = head_cmd.pm;
					res.hour_rejected = !head_cmd.hour_ok;
					res.minute_rejected = !head_cmd.minute_ok;
					res.second_rejected = !head_cmd.second_ok;
				end
				tdc_pkg::KIND_COMPARE: begin
					res.times_equal = cmp_eq;
					res.time_greater = cmp_gt;
				end
				default: begin
					res.times_equal = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hours_q <= '0;
			minutes_q <= '0;
			seconds_q <= '0;
			pm_q <= 1'b0;
			remain_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (do_tick) begin
				hours_q <= tick_hours;
				minutes_q <= tick_minutes;
				seconds_q <= tick_seconds;
				pm_q <= tick_pm;
			end else if (emit && (state_q == ST_IDLE)
					&& (head_cmd.kind == tdc_pkg::KIND_SET)) begin
				hours_q <= res.hour;
				minutes_q <= res.minute;
				seconds_q <= res.second;
				pm_q <= res.pm;
			end
			case (state_q)
				ST_IDLE: begin
					if (start_adv) begin
						remain_q <= head_cmd.count - 17'd1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (remain_q != '0) begin
						remain_q <= remain_q - 17'd1;
					end else if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

/* design/time_of_day_counter_12_24.sv */
// Top level of the 12/24-hour time-of-day counter.
//
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------------
//  in       | s_tvalid/s_tready  | s_tuser: action; s_tdata: hour, minute, second,...
//  out      | m_tvalid/m_tready  | m_tdata: hour, minute, second, pm, flags
//  config   | cfg_wr_en          | cfg_wr_data: twelve_hour_mode
//
// Set, compare, zero advances and the unused action are popped and answered together; an
// advance of n seconds is popped at once and stepped n times by the one-tick-per-cycle counter.
// The queue holds QUEUE_DEPTH words, so input keeps being taken while the back end ticks until it fills.
// Reset clears the time to 00:00:00 AM and selects 24-hour counting.
// The result register holds a word until m_tready; the back end stalls only when it is full and m_tready is low.
`default_nettype none
module time_of_day_counter_12_24 #(
	parameter int QUEUE_DEPTH = 2
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// [1:0] action
	input wire logic [1:0] s_tuser,
	// [5:0] hour_in, [11:6] minute_in, [17:12] second_in, [18] pm_in,
	// [19] other_twelve_hour, [36:20] advance_count, [39:37] zero
	input wire logic [tdc_pkg::IN_DATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// [4:0] hour_out, [10:5] minute_out, [16:11] second_out, [17] pm_out,
	// [18] times_equal, [19] time_greater, [20] hour_rejected,
	// [21] minute_rejected, [22] second_rejected, [23] zero
	output logic [tdc_pkg::OUT_DATA_W-1:0] m_tdata,
	input wire logic cfg_wr_en,
	input wire logic cfg_wr_data
);

	logic twelve_hour_mode_q;
	logic q_full;
	logic q_push;
	logic q_pop;
	logic head_valid;
	tdc_pkg::cmd_t push_cmd;
	tdc_pkg::cmd_t head_cmd;
	tdc_pkg::result_t result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			twelve_hour_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			twelve_hour_mode_q <= cfg_wr_data;
		end
	end

	tdc_front u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser(s_tuser),
		.s_tdata(s_tdata),
		.twelve_hour_mode(twelve_hour_mode_q),
		.q_full(q_full),
		.q_push(q_push),
		.q_cmd(push_cmd)
	);

	tdc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_cmd(push_cmd),
		.full(q_full),
		.pop(q_pop),
		.head_valid(head_valid),
		.head_cmd(head_cmd)
	);

	tdc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.twelve_hour_mode(twelve_hour_mode_q),
		.head_valid(head_valid),
		.head_cmd(head_cmd),
		.pop(q_pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_result(result)
	);

	assign m_tdata = {1'b0, result};

endmodule
`default_nettype wire
